### design/ldiv_pkg.sv
`default_nettype none

package ldiv_pkg;

   localparam int NUM_WIDTH = 32;
   localparam int DEN_WIDTH = 32;

   typedef struct packed {
      logic                 valid;
      logic                 neg;
      logic [DEN_WIDTH-1:0] den;
      logic [NUM_WIDTH-1:0] num;
      logic [NUM_WIDTH-1:0] quo;
      logic [DEN_WIDTH-1:0] rem;
   } ldiv_cell_type;

endpackage

`default_nettype wire

### design/ldiv_front.sv
`default_nettype none

module ldiv_front import ldiv_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic                 signed_mode,
   input  wire logic [NUM_WIDTH-1:0] dividend_bits,
   input  wire logic [DEN_WIDTH-1:0] divisor,
   output      ldiv_cell_type        cell_out
);

   ldiv_cell_type front_ff;
   ldiv_cell_type front_in;

   always_comb begin
      front_in       = '0;
      front_in.valid = accept;
      front_in.neg   = signed_mode & dividend_bits[NUM_WIDTH-1];
      front_in.den   = divisor;
      front_in.num   = front_in.neg ? (~dividend_bits + NUM_WIDTH'(1)) : dividend_bits;
      front_in.quo   = '0;
      front_in.rem   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
      end else begin
         front_ff.valid <= front_in.valid;
      end
      front_ff.neg <= front_in.neg;
      front_ff.den <= front_in.den;
      front_ff.num <= front_in.num;
      front_ff.quo <= front_in.quo;
      front_ff.rem <= front_in.rem;
   end

   assign cell_out = front_ff;

endmodule

`default_nettype wire

### design/ldiv_cell.sv
`default_nettype none

module ldiv_cell import ldiv_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ldiv_cell_type cell_in,
   output      ldiv_cell_type cell_out
);

   ldiv_cell_type        cell_ff;
   ldiv_cell_type        cell_in_next;
   logic [DEN_WIDTH:0]   window;
   logic [DEN_WIDTH:0]   diff;
   logic                 fits;

   always_comb begin
      window = {cell_in.rem, cell_in.num[NUM_WIDTH-1]};
      diff   = window - {1'b0, cell_in.den};
      fits   = (window >= {1'b0, cell_in.den});

      cell_in_next       = cell_in;
      cell_in_next.rem   = fits ? diff[DEN_WIDTH-1:0] : window[DEN_WIDTH-1:0];
      cell_in_next.num   = {cell_in.num[NUM_WIDTH-2:0], 1'b0};
      cell_in_next.quo   = {cell_in.quo[NUM_WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in_next.valid;
      end
      cell_ff.neg <= cell_in_next.neg;
      cell_ff.den <= cell_in_next.den;
      cell_ff.num <= cell_in_next.num;
      cell_ff.quo <= cell_in_next.quo;
      cell_ff.rem <= cell_in_next.rem;
   end

   assign cell_out = cell_ff;

endmodule

`default_nettype wire

### design/ldiv_back.sv
`default_nettype none

module ldiv_back import ldiv_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ldiv_cell_type        cell_in,
   output      logic                 strobe,
   output      logic [NUM_WIDTH-1:0] quotient_bits
);

   logic                 strobe_ff;
   logic [NUM_WIDTH-1:0] quotient_ff;
   logic [NUM_WIDTH-1:0] quotient_in;

   assign quotient_in = cell_in.neg ? (~cell_in.quo + NUM_WIDTH'(1)) : cell_in.quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      quotient_ff <= quotient_in;
   end

   assign strobe        = strobe_ff;
   assign quotient_bits = quotient_ff;

endmodule

`default_nettype wire

### design/restoring_long_divider.sv
// Throughput: one transaction per cycle; busy stays low.
// The pipeline is one register stage for sign handling in, one cell per quotient bit, one out.
// Synchronous active-high reset clears the stage valid bits and the mode register.
// Results appear on rsp_ for one cycle with rsp_strobe; the receiver cannot stall.
`default_nettype none

module restoring_long_divider import ldiv_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire logic [NUM_WIDTH-1:0] req_dividend_bits,
   input  wire logic [DEN_WIDTH-1:0] req_divisor,
   output      logic                 rsp_strobe,
   output      logic [NUM_WIDTH-1:0] rsp_quotient_bits,
   input  wire logic                 csr_write_enable,
   input  wire logic                 csr_write_data
);

   logic          signed_numerator_ff;
   logic          signed_numerator_in;
   ldiv_cell_type cell_link [0:NUM_WIDTH];

   assign busy = 1'b0;

   assign signed_numerator_in = csr_write_enable ? csr_write_data : signed_numerator_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_numerator_ff <= 1'b0;
      end else begin
         signed_numerator_ff <= signed_numerator_in;
      end
   end

   ldiv_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (start & ~busy),
      .signed_mode   (signed_numerator_ff),
      .dividend_bits (req_dividend_bits),
      .divisor       (req_divisor),
      .cell_out      (cell_link[0])
   );

   for (genvar i = 0; i < NUM_WIDTH; i++) begin : g_cell
      ldiv_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (cell_link[i]),
         .cell_out (cell_link[i+1])
      );
   end

   ldiv_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cell_in       (cell_link[NUM_WIDTH]),
      .strobe        (rsp_strobe),
      .quotient_bits (rsp_quotient_bits)
   );

endmodule

`default_nettype wire

### design/ldiv_checker.sv
`default_nettype none

module ldiv_checker import ldiv_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire logic                 busy,
   input wire logic [NUM_WIDTH-1:0] req_dividend_bits,
   input wire logic [DEN_WIDTH-1:0] req_divisor,
   input wire logic                 rsp_strobe,
   input wire logic [NUM_WIDTH-1:0] rsp_quotient_bits
);

   localparam int LATENCY = NUM_WIDTH + 2;

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("transaction produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without transaction");

   a_unit_divisor: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_divisor, LATENCY) == DEN_WIDTH'(1))
      |-> rsp_quotient_bits == $past(req_dividend_bits, LATENCY))
      else $error("division by one changed the dividend");

endmodule

bind restoring_long_divider ldiv_checker u_ldiv_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_dividend_bits (req_dividend_bits),
   .req_divisor       (req_divisor),
   .rsp_strobe        (rsp_strobe),
   .rsp_quotient_bits (rsp_quotient_bits)
);

`default_nettype wire
